// File: sv/mvam_pkg.sv
// shared types, constants and codes for the multi-voice audio mixer
// no dependencies; imported by every module of the block
`default_nettype none

package mvam_pkg;

    // parameter defaults
    localparam int VOICES_DEF       = 8;
    localparam int BUFFER_BYTES_DEF = 16384;
    localparam int LENGTH_BITS_DEF  = 24;

    // field widths
    localparam int OP_W      = 2;
    localparam int VIDX_IN_W = 3;
    localparam int LEN_IN_W  = 24;
    localparam int SAMPLE_W  = 16;
    localparam int KIND_W    = 2;
    localparam int SLOT_W    = 3;
    localparam int ACC_W     = 20;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // accumulator and clamp limits
    localparam int ACC_MAX = (1 << (ACC_W - 1)) - 1;
    localparam int ACC_MIN = -(1 << (ACC_W - 1));
    localparam int MID_8   = 128;
    localparam int MAX_8   = 255;
    localparam int MAX_16  = 32767;
    localparam int MIN_16  = -32768;

    // operation codes
    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SLOT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NO_SLOT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MIX     = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [VIDX_IN_W-1:0] voice_index;
        logic [LEN_IN_W-1:0]  sample_length;
        logic                 loop_flag;
        logic [SAMPLE_W-1:0]  sample_value;
        logic                 frame_last;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   result_kind;
        logic [SLOT_W-1:0]   slot;
        logic [SAMPLE_W-1:0] mixed_sample;
        logic                buffer_end;
    } result_t;

    // voice table to mixer: addressed voice in range for each mode
    typedef struct packed {
        logic hit8;
        logic hit16;
    } voice_look_t;

    // voice table to top: outcome of a start word
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } start_t;

    // mixer to top and voice table
    typedef struct packed {
        logic                frame_done;
        logic                buffer_end;
        logic [SAMPLE_W-1:0] mixed_sample;
    } mix_res_t;

endpackage

`default_nettype wire

// File: sv/multi_voice_audio_mixer.sv
// a result word passes through the input register and then the result register before it appears on m_
// throughput: one input word per cycle; the input register passes on whenever the
// result register is empty or being taken, or the word makes no result
// reset (aresetn low, synchronous): all slots free, accumulator and frame position
// cleared, 8-bit mode; slot length tables keep their contents
// top level of the multi-voice audio mixer; uses mvam_pkg, mvam_voices, mvam_mix, mvam_out
`default_nettype none

module multi_voice_audio_mixer #(
    parameter int VOICES       = mvam_pkg::VOICES_DEF,
    parameter int BUFFER_BYTES = mvam_pkg::BUFFER_BYTES_DEF,
    parameter int LENGTH_BITS  = mvam_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration: sample_mode
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_data,
    // input words
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // voice_index, sample_length, loop_flag, sample_value
    input  wire logic [mvam_pkg::S_TDATA_W-1:0] s_tdata,
    // operation
    input  wire logic [mvam_pkg::OP_W-1:0]     s_tuser,
    // frame_last
    input  wire logic                          s_tlast,
    // result words
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // slot, mixed_sample
    output logic [mvam_pkg::M_TDATA_W-1:0]     m_tdata,
    // result_kind
    output logic [mvam_pkg::KIND_W-1:0]        m_tuser,
    // buffer_end
    output logic                               m_tlast
);
    import mvam_pkg::*;

    localparam int POS_W = $clog2(BUFFER_BYTES);

    logic        in_valid_reg, in_valid_next;
    item_t       item_reg;
    item_t       item_in;
    logic        has_result, adv, accept;
    voice_look_t look;
    start_t      start;
    mix_res_t    mix_res;
    logic [POS_W-1:0] frame_pos;
    result_t     res;

    assign item_in.operation     = s_tuser;
    assign item_in.voice_index   = s_tdata[2:0];
    assign item_in.sample_length = s_tdata[26:3];
    assign item_in.loop_flag     = s_tdata[27];
    assign item_in.sample_value  = s_tdata[43:28];
    assign item_in.frame_last    = s_tlast;

    assign has_result = (item_reg.operation == OP_START) ||
                        ((item_reg.operation == OP_SAMPLE) && item_reg.frame_last);
    assign adv        = in_valid_reg && (!has_result || !m_tvalid || m_tready);
    assign s_tready   = !in_valid_reg || adv;
    assign accept     = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_in;
        end
    end

    mvam_voices #(
        .VOICES       (VOICES),
        .BUFFER_BYTES (BUFFER_BYTES),
        .LENGTH_BITS  (LENGTH_BITS),
        .POS_W        (POS_W)
    ) u_voices (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (adv),
        .item      (item_reg),
        .frame_pos (frame_pos),
        .advance   (mix_res.buffer_end),
        .look      (look),
        .start     (start)
    );

    mvam_mix #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .POS_W        (POS_W)
    ) u_mix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (adv),
        .item        (item_reg),
        .look        (look),
        .frame_pos   (frame_pos),
        .res         (mix_res)
    );

    always_comb begin
        res = '0;
        if (item_reg.operation == OP_START) begin
            if (start.found) begin
                res.result_kind = KIND_SLOT;
                res.slot        = start.slot;
            end else begin
                res.result_kind = KIND_NO_SLOT;
            end
        end else begin
            res.result_kind  = KIND_MIX;
            res.mixed_sample = mix_res.mixed_sample;
            res.buffer_end   = mix_res.buffer_end;
        end
    end

    mvam_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (adv && has_result),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: sv/mvam_voices.sv
// voice slot table: active, looping, length and remaining bytes per slot
// free-slot search, stop, range lookup and per-buffer advance; uses mvam_pkg
`default_nettype none

module mvam_voices #(
    parameter int VOICES       = mvam_pkg::VOICES_DEF,
    parameter int BUFFER_BYTES = mvam_pkg::BUFFER_BYTES_DEF,
    parameter int LENGTH_BITS  = mvam_pkg::LENGTH_BITS_DEF,
    parameter int POS_W        = $clog2(mvam_pkg::BUFFER_BYTES_DEF)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  fire,
    input  wire mvam_pkg::item_t       item,
    input  wire logic [POS_W-1:0]      frame_pos,
    input  wire logic                  advance,
    output mvam_pkg::voice_look_t      look,
    output mvam_pkg::start_t           start
);
    import mvam_pkg::*;

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int BUF_W  = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W  = ((LENGTH_BITS > BUF_W) ? LENGTH_BITS : BUF_W) + 1;

    logic [VOICES-1:0]      active_reg, active_next;
    logic [VOICES-1:0]      looping_reg, looping_next;
    logic [LENGTH_BITS-1:0] length_reg [VOICES];
    logic [LENGTH_BITS-1:0] length_next [VOICES];
    logic [LENGTH_BITS-1:0] remaining_reg [VOICES];
    logic [LENGTH_BITS-1:0] remaining_next [VOICES];

    logic                   free_found;
    logic [VIDX_W-1:0]      free_idx;
    logic                   vi_ok;
    logic [VIDX_W-1:0]      vi_idx;
    logic [LENGTH_BITS-1:0] len_in;
    logic [LENGTH_BITS-1:0] rem_sel;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = VOICES - 1; k >= 0; k--) begin
            if (!active_reg[k]) begin
                free_found = 1'b1;
                free_idx   = VIDX_W'(k);
            end
        end
    end

    assign start.found = free_found;
    assign start.slot  = SLOT_W'(free_idx);

    assign vi_ok   = 32'(item.voice_index) < 32'(VOICES);
    assign vi_idx  = VIDX_W'(item.voice_index);
    assign len_in  = LENGTH_BITS'(item.sample_length);
    assign rem_sel = remaining_reg[vi_idx];

    assign look.hit8  = vi_ok && active_reg[vi_idx] &&
                        (CMP_W'(frame_pos) < CMP_W'(rem_sel));
    assign look.hit16 = vi_ok && active_reg[vi_idx] &&
                        (CMP_W'(frame_pos) < CMP_W'(rem_sel >> 1));

    always_comb begin
        active_next    = active_reg;
        looping_next   = looping_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        if (fire) begin
            unique case (item.operation)
                OP_START: begin
                    if (free_found) begin
                        active_next[free_idx]    = 1'b1;
                        looping_next[free_idx]   = item.loop_flag;
                        length_next[free_idx]    = len_in;
                        remaining_next[free_idx] = len_in;
                    end
                end
                OP_STOP: begin
                    if (vi_ok) begin
                        active_next[vi_idx]  = 1'b0;
                        looping_next[vi_idx] = 1'b0;
                    end
                end
                default: ;
            endcase
            if (advance) begin
                for (int k = 0; k < VOICES; k++) begin
                    if (active_reg[k]) begin
                        if (CMP_W'(remaining_reg[k]) <= CMP_W'(BUFFER_BYTES)) begin
                            if (looping_reg[k]) begin
                                remaining_next[k] = length_reg[k];
                            end else begin
                                active_next[k] = 1'b0;
                            end
                        end else begin
                            remaining_next[k] = LENGTH_BITS'(CMP_W'(remaining_reg[k])
                                                - CMP_W'(BUFFER_BYTES));
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= '0;
            looping_reg <= '0;
        end else begin
            active_reg  <= active_next;
            looping_reg <= looping_next;
        end
    end

    always_ff @(posedge aclk) begin
        length_reg    <= length_next;
        remaining_reg <= remaining_next;
    end

endmodule

`default_nettype wire

// File: sv/mvam_mix.sv
// mix accumulator, frame position counter and sample mode register
// saturating add per word and output clamp at frame end; uses mvam_pkg
`default_nettype none

module mvam_mix #(
    parameter int BUFFER_BYTES = mvam_pkg::BUFFER_BYTES_DEF,
    parameter int POS_W        = $clog2(mvam_pkg::BUFFER_BYTES_DEF)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_wr_data,
    input  wire logic                  fire,
    input  wire mvam_pkg::item_t       item,
    input  wire mvam_pkg::voice_look_t look,
    output logic [POS_W-1:0]           frame_pos,
    output mvam_pkg::mix_res_t         res
);
    import mvam_pkg::*;

    localparam int LIMIT_8  = BUFFER_BYTES;
    localparam int LIMIT_16 = BUFFER_BYTES / 2;

    logic                    mode_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [POS_W-1:0]        pos_reg, pos_next;

    logic signed [9:0]          s8;
    logic signed [SAMPLE_W-1:0] s16;
    logic signed [ACC_W:0]      sum8, sum16, out8;
    logic signed [ACC_W-1:0]    sat8, sat16, acc_add;
    logic                       is_sample, hit, wrap;
    logic [POS_W:0]             pos_inc, limit;
    logic [SAMPLE_W-1:0]        mixed;

    assign is_sample = item.operation == OP_SAMPLE;
    assign hit       = is_sample && (mode_reg ? look.hit16 : look.hit8);

    assign s8    = $signed({2'b00, item.sample_value[7:0]}) - 10'(MID_8);
    assign s16   = $signed(item.sample_value);
    assign sum8  = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(s8);
    assign sum16 = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(s16);

    always_comb begin
        if (sum8 > ACC_MAX) begin
            sat8 = ACC_W'(ACC_MAX);
        end else if (sum8 < ACC_MIN) begin
            sat8 = ACC_W'(ACC_MIN);
        end else begin
            sat8 = ACC_W'(sum8);
        end
        if (sum16 > MAX_16) begin
            sat16 = ACC_W'(MAX_16);
        end else if (sum16 < MIN_16) begin
            sat16 = ACC_W'(MIN_16);
        end else begin
            sat16 = ACC_W'(sum16);
        end
    end

    assign acc_add = hit ? (mode_reg ? sat16 : sat8) : acc_reg;
    assign out8    = (ACC_W+1)'(acc_add) + (ACC_W+1)'(MID_8);

    always_comb begin
        if (mode_reg) begin
            if (acc_add > MAX_16) begin
                mixed = SAMPLE_W'(MAX_16);
            end else if (acc_add < MIN_16) begin
                mixed = SAMPLE_W'(MIN_16);
            end else begin
                mixed = SAMPLE_W'(acc_add);
            end
        end else begin
            if (out8 > MAX_8) begin
                mixed = SAMPLE_W'(MAX_8);
            end else if (out8 < 0) begin
                mixed = '0;
            end else begin
                mixed = SAMPLE_W'(out8);
            end
        end
    end

    assign pos_inc = (POS_W+1)'(pos_reg) + 1'b1;
    assign limit   = mode_reg ? (POS_W+1)'(LIMIT_16) : (POS_W+1)'(LIMIT_8);
    assign wrap    = pos_inc >= limit;

    assign res.frame_done   = fire && is_sample && item.frame_last;
    assign res.buffer_end   = res.frame_done && wrap;
    assign res.mixed_sample = mixed;
    assign frame_pos        = pos_reg;

    always_comb begin
        acc_next = acc_reg;
        pos_next = pos_reg;
        if (fire && is_sample) begin
            if (item.frame_last) begin
                acc_next = '0;
                pos_next = wrap ? '0 : pos_inc[POS_W-1:0];
            end else begin
                acc_next = acc_add;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            acc_reg  <= '0;
            pos_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            acc_reg <= acc_next;
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/mvam_out.sv
// result register on the master side of the mixer
// holds one result word until taken; uses mvam_pkg
`default_nettype none

module mvam_out (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       load,
    input  wire mvam_pkg::result_t          res,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [mvam_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [mvam_pkg::KIND_W-1:0]     m_tuser,
    output logic                            m_tlast
);
    import mvam_pkg::*;

    localparam int PAD_W = M_TDATA_W - SLOT_W - SAMPLE_W;

    logic    valid_reg, valid_next;
    result_t res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, res_reg.mixed_sample, res_reg.slot};
    assign m_tuser  = res_reg.result_kind;
    assign m_tlast  = res_reg.buffer_end;

endmodule

`default_nettype wire

// File: sv/mvam_checker.sv
// port-level checks for the multi-voice audio mixer, bound to the top level
// uses mvam_pkg; sees only the top level's ports
`default_nettype none

module mvam_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mvam_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [mvam_pkg::KIND_W-1:0]   m_tuser,
    input wire logic                          m_tlast
);
    import mvam_pkg::*;

    // no result word straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("stalled result word changed");

    // a free or draining result side never blocks the input side
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled while result side free");

    // slot reports carry no mix and never close a buffer
    a_slot_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_MIX) |-> !m_tlast &&
                                             (m_tdata[SLOT_W +: SAMPLE_W] == '0))
        else $error("slot report with mix fields set");

endmodule

bind multi_voice_audio_mixer mvam_checker u_mvam_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
